### rtl/mie_pkg.sv
`timescale 1ns / 1ps
// shared constants, opcodes and function codes of the instruction executor
package mie_pkg;

    localparam int DATA_WORDS = 1024;
    localparam int SLOT_BITS  = $clog2(DATA_WORDS);
    localparam int IN_BITS    = 32;
    localparam int OUT_BITS   = 208;
    localparam int REG_BITS   = 5;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0]  LINK_REG  = 5'd31;
    localparam logic [4:0]  EXIT_REG  = 5'd2;
    localparam logic [31:0] EXIT_CODE = 32'h0000_000A;

    typedef struct packed {
        logic                wr_en;
        logic [REG_BITS-1:0] wr_idx;
        logic [31:0]         wr_data;
    } rf_write_t;

endpackage

### rtl/mie_regfile.sv
`timescale 1ns / 1ps
// register file: two synchronous read ports, one write port, reset through valid bits
module mie_regfile (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mie_pkg::rf_write_t                wr,
    input  logic                              rd_en,
    input  logic [mie_pkg::REG_BITS-1:0]      rd_idx_a,
    input  logic [mie_pkg::REG_BITS-1:0]      rd_idx_b,
    output logic [31:0]                       rd_data_a,
    output logic [31:0]                       rd_data_b
);
    import mie_pkg::*;

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] valid_next;
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic        ok_a_reg;
    logic        ok_b_reg;

    always_comb begin
        valid_next = valid_reg;
        if (wr.wr_en) begin
            valid_next[wr.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            mem[wr.wr_idx] <= wr.wr_data;
        end
        if (rd_en) begin
            q_a_reg  <= mem[rd_idx_a];
            q_b_reg  <= mem[rd_idx_b];
            ok_a_reg <= valid_reg[rd_idx_a];
            ok_b_reg <= valid_reg[rd_idx_b];
        end
    end

    assign rd_data_a = ok_a_reg ? q_a_reg : '0;
    assign rd_data_b = ok_b_reg ? q_b_reg : '0;

endmodule

### rtl/mips_integer_instruction_executor.sv
`timescale 1ns / 1ps
// top level of the mips-i integer instruction executor
// Each beat on the slave side is one instruction taken at the current program counter;
// each beat on the master side is its result. An instruction passes three steps:
// register file read, data store read, then execute and write back into the register
// file and data store. A new instruction is taken once the previous one has left the
// register read step and the execute step is free or passing its result on; a
// write-back that lands on the same edge as the register file read is bypassed.
// Results wait in an output register without stopping the next read. The data store
// holds 1024 words, read before written.
module mips_integer_instruction_executor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mie_pkg::IN_BITS-1:0]   s_tdata,   // instruction_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc, wrote_register, dest_index, dest_value, stored, store_address, halt,
    // illegal, cycles_total, instructions_total, accesses_total, zero fill
    output logic [mie_pkg::OUT_BITS-1:0]  m_tdata
);
    import mie_pkg::*;

    logic        v1_reg, v1_next, v2_reg, v2_next, m_valid_reg, m_valid_next;
    logic        accept, adv1, adv2;
    logic [31:0] ins1_reg, ins2_reg;
    logic        hit_a_reg, hit_b_reg;
    logic [31:0] byp_reg;
    logic [31:0] ra, rb, a1, b1, a2_reg, b2_reg, addr2_reg, dm_q_reg, simm1;
    logic [SLOT_BITS-1:0] slot1;
    logic [31:0] pc_reg, cyc_reg, insn_reg, acc_reg;
    logic        r2_ten_reg;
    logic [OUT_BITS-1:0] m_data_reg;
    logic [31:0] dmem [DATA_WORDS];
    rf_write_t   wb;

    // execute step signals
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sa;
    logic [31:0] imm, simm, a, b, w, nxt, wval, addr, sword, pc4, lo8, lo16;
    logic [4:0]  widx;
    logic        wr, st, ill, stv, halt;
    logic [2:0]  cyc;
    logic        acc;

    assign accept = s_tvalid && s_tready;
    assign adv2   = v2_reg && (!m_valid_reg || m_tready);
    assign adv1   = v1_reg && (!v2_reg || adv2);
    assign s_tready = !v1_reg && (!v2_reg || adv2);

    always_comb begin
        v1_next = v1_reg;
        if (accept) begin
            v1_next = 1'b1;
        end else if (adv1) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (adv1) begin
            v2_next = 1'b1;
        end else if (adv2) begin
            v2_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (adv2) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            pc_reg      <= '0;
            cyc_reg     <= '0;
            insn_reg    <= '0;
            acc_reg     <= '0;
            r2_ten_reg  <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
            if (adv2 && !ill) begin
                pc_reg   <= nxt;
                cyc_reg  <= cyc_reg + 32'(cyc);
                insn_reg <= insn_reg + 32'd1;
                acc_reg  <= acc_reg + 32'(acc);
                r2_ten_reg <= halt;
            end
        end
    end

    mie_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wb),
        .rd_en     (accept),
        .rd_idx_a  (s_tdata[25:21]),
        .rd_idx_b  (s_tdata[20:16]),
        .rd_data_a (ra),
        .rd_data_b (rb)
    );

    // read step: bypass a write-back that lands on the read edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            ins1_reg  <= s_tdata;
            hit_a_reg <= wb.wr_en && (wb.wr_idx == s_tdata[25:21]);
            hit_b_reg <= wb.wr_en && (wb.wr_idx == s_tdata[20:16]);
            byp_reg   <= wb.wr_data;
        end
    end

    assign a1    = hit_a_reg ? byp_reg : ra;
    assign b1    = hit_b_reg ? byp_reg : rb;
    assign simm1 = {{16{ins1_reg[15]}}, ins1_reg[15:0]};
    assign slot1 = SLOT_BITS'((a1 + simm1) >> 2);

    always_ff @(posedge aclk) begin
        if (adv2 && stv) begin
            dmem[addr[SLOT_BITS+1:2]] <= sword;
        end
        if (adv1) begin
            ins2_reg  <= ins1_reg;
            a2_reg    <= a1;
            b2_reg    <= b1;
            addr2_reg <= a1 + simm1;
            if (adv2 && stv && (addr[SLOT_BITS+1:2] == slot1)) begin
                dm_q_reg <= sword;
            end else begin
                dm_q_reg <= dmem[slot1];
            end
        end
    end

    // execute step
    always_comb begin
        op   = ins2_reg[31:26];
        rt   = ins2_reg[20:16];
        rd   = ins2_reg[15:11];
        sa   = ins2_reg[10:6];
        fn   = ins2_reg[5:0];
        imm  = {16'h0000, ins2_reg[15:0]};
        simm = {{16{ins2_reg[15]}}, ins2_reg[15:0]};
        a    = a2_reg;
        b    = b2_reg;
        w    = dm_q_reg;
        pc4  = pc_reg + 32'd4;
        nxt  = pc4;
        cyc  = 3'd4;
        acc  = 1'b0;
        addr = '0;
        widx = '0;
        wval = '0;
        wr   = 1'b0;
        st   = 1'b0;
        ill  = 1'b0;
        sword = w;
        lo8  = '0;
        lo16 = '0;
        unique case (op)
            OP_SPECIAL: begin
                wr   = 1'b1;
                widx = rd;
                unique case (fn)
                    FN_SLL:  wval = b << sa;
                    FN_SRL:  wval = b >> sa;
                    FN_SRA:  wval = 32'($signed(b) >>> sa);
                    FN_SLLV: wval = b << a[4:0];
                    FN_SRLV: wval = b >> a[4:0];
                    FN_SRAV: wval = 32'($signed(b) >>> a[4:0]);
                    FN_JR: begin
                        wr  = 1'b0;
                        nxt = a;
                        cyc = 3'd3;
                    end
                    FN_JALR: begin
                        wval = pc4;
                        nxt  = a;
                    end
                    FN_ADD, FN_ADDU: wval = a + b;
                    FN_SUB, FN_SUBU: wval = a - b;
                    FN_AND:  wval = a & b;
                    FN_OR:   wval = a | b;
                    FN_XOR:  wval = a ^ b;
                    FN_NOR:  wval = ~(a | b);
                    FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
                    FN_SLTU: wval = {31'd0, a < b};
                    default: ill = 1'b1;
                endcase
            end
            OP_J: begin
                nxt = {pc4[31:28], ins2_reg[25:0], 2'b00};
                cyc = 3'd3;
            end
            OP_JAL: begin
                nxt  = {pc4[31:28], ins2_reg[25:0], 2'b00};
                wr   = 1'b1;
                widx = LINK_REG;
                wval = pc4;
            end
            OP_BEQ: begin
                if (a == b) begin
                    nxt = pc4 + {simm[29:0], 2'b00};
                end
            end
            OP_BNE: begin
                if (a != b) begin
                    nxt = pc4 + {simm[29:0], 2'b00};
                end
            end
            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
                wr   = 1'b1;
                widx = rt;
                unique case (op)
                    OP_ADDI, OP_ADDIU: wval = a + simm;
                    OP_SLTI:  wval = {31'd0, $signed(a) < $signed(simm)};
                    OP_SLTIU: wval = {31'd0, a < simm};
                    OP_ANDI:  wval = a & imm;
                    OP_ORI:   wval = a | imm;
                    OP_XORI:  wval = a ^ imm;
                    default: begin
                        wval = {ins2_reg[15:0], 16'h0000};
                        acc  = 1'b1;
                    end
                endcase
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                addr = addr2_reg;
                wr   = 1'b1;
                widx = rt;
                acc  = 1'b1;
                case (addr2_reg[1:0])
                    2'd0:    lo8 = {24'd0, w[31:24]};
                    2'd1:    lo8 = {24'd0, w[23:16]};
                    2'd2:    lo8 = {24'd0, w[15:8]};
                    default: lo8 = {24'd0, w[7:0]};
                endcase
                lo16 = addr2_reg[1] ? {16'd0, w[15:0]} : {16'd0, w[31:16]};
                unique case (op)
                    OP_LB:   wval = {{24{lo8[7]}}, lo8[7:0]};
                    OP_LBU:  wval = lo8;
                    OP_LH:   wval = {{16{lo16[15]}}, lo16[15:0]};
                    OP_LHU:  wval = lo16;
                    default: wval = w;
                endcase
            end
            OP_SB, OP_SH, OP_SW: begin
                addr = addr2_reg;
                st   = 1'b1;
                acc  = 1'b1;
                unique case (op)
                    OP_SB: begin
                        case (addr2_reg[1:0])
                            2'd0:    sword = {b[7:0], w[23:0]};
                            2'd1:    sword = {w[31:24], b[7:0], w[15:0]};
                            2'd2:    sword = {w[31:16], b[7:0], w[7:0]};
                            default: sword = {w[31:8], b[7:0]};
                        endcase
                    end
                    OP_SH: begin
                        sword = addr2_reg[1] ? {w[31:16], b[15:0]} : {b[15:0], w[15:0]};
                    end
                    default: sword = b;
                endcase
            end
            default: ill = 1'b1;
        endcase
        if (ill) begin
            nxt  = pc_reg;
            wr   = 1'b0;
            st   = 1'b0;
            addr = '0;
            acc  = 1'b0;
        end
        if (wr && widx == '0) begin
            wr = 1'b0;
        end
        if (!wr) begin
            widx = '0;
            wval = '0;
        end
        stv  = st;
        halt = (wr && widx == EXIT_REG) ? (wval == EXIT_CODE) : r2_ten_reg;
    end

    assign wb.wr_en   = adv2 && wr;
    assign wb.wr_idx  = widx;
    assign wb.wr_data = wval;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_data_reg <= {7'd0,
                           ill ? acc_reg : acc_reg + 32'(acc),
                           ill ? insn_reg : insn_reg + 32'd1,
                           ill ? cyc_reg : cyc_reg + 32'(cyc),
                           ill, halt, addr, st, wval, widx, wr, nxt};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/mie_checker.sv
`timescale 1ns / 1ps
// port-level checks of the instruction executor and their binding
module mie_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mie_pkg::IN_BITS-1:0]   s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mie_pkg::OUT_BITS-1:0]  m_tdata
);
    import mie_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken during register read");

    a_illegal_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[104] |-> !m_tdata[32] && !m_tdata[70] &&
            (m_tdata[102:71] == 32'd0))
        else $error("illegal instruction wrote state");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> (m_tdata[37:33] == 5'd0) &&
            (m_tdata[69:38] == 32'd0))
        else $error("destination fields set without a write");

endmodule

bind mips_integer_instruction_executor mie_checker u_mie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
